// ===== design/srlt_pkg.sv =====
// ----------------------------------------------------------------------------
// srlt_pkg
// Shared constants, codes and transaction types of the sparse row level tracker.
// ----------------------------------------------------------------------------
package srlt_pkg;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_NONZEROS = 1024;
    localparam int LEVEL_W      = 16;
    localparam int PART_W       = 8;
    localparam int WEIGHT_W     = 20;
    localparam int DIV_W        = 18;

    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int NZ_AW    = $clog2(MAX_NONZEROS);
    localparam int RS_DEPTH = MAX_ROWS + 1;
    localparam int RS_AW    = $clog2(RS_DEPTH);
    localparam int PTR_W    = NZ_AW + 1;

    localparam int ACTION_W = 4;
    localparam int ROWF_W   = 9;
    localparam int ENTRY_W  = 10;
    localparam int VALUE_W  = 11;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_LOAD_START = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_COL   = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_PART  = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_MARK       = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_CAN_ADD    = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE    = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_REWEIGH    = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_READ_WT    = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_MIN_LEVEL  = 4'd8;

    localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = 20'd1000000;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = {LEVEL_W{1'b1}};
    localparam logic [COUNT_W-1:0]  ROW_COUNT_RESET = 9'd256;

    localparam logic [0:0] REG_ROW_COUNT = 1'b0;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [LEVEL_W-1:0]  level_below;
        logic [ENTRY_W-1:0]  entry;
        logic [ROWF_W-1:0]   row;
        logic [ACTION_W-1:0] action;
    } srlt_item_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_out;
        logic [LEVEL_W-1:0]  level_out;
        logic                flag;
    } srlt_result_t;

endpackage

// ===== design/srlt_div.sv =====
// ----------------------------------------------------------------------------
// srlt_div
// Bit-serial restoring divider of the weight constant by a run-time divisor.
// ----------------------------------------------------------------------------
module srlt_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [srlt_pkg::DIV_W-1:0]    divisor,
    output logic                          busy,
    output logic                          done,
    output logic [srlt_pkg::WEIGHT_W-1:0] quotient
);
    import srlt_pkg::*;

    localparam int CNT_W = $clog2(WEIGHT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WEIGHT_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [WEIGHT_W-1:0] dvd_reg;
    logic [WEIGHT_W-1:0] quo_reg;
    logic [DIV_W:0]      trial;
    logic                fits;

    assign trial = {rem_reg, dvd_reg[WEIGHT_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                div_reg  <= divisor;
                rem_reg  <= '0;
                dvd_reg  <= WEIGHT_TOP;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
                dvd_reg <= {dvd_reg[WEIGHT_W-2:0], 1'b0};
                quo_reg <= {quo_reg[WEIGHT_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/srlt_engine.sv =====
// ----------------------------------------------------------------------------
// srlt_engine
// Sequencer around the structure, done, level and weight memories.
// ----------------------------------------------------------------------------
module srlt_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  srlt_pkg::srlt_item_t         in_item,
    input  logic [srlt_pkg::COUNT_W-1:0] rows_used,
    output logic                         res_valid,
    input  logic                         res_ready,
    output srlt_pkg::srlt_result_t       res
);
    import srlt_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_CA1, ST_CA2,
        ST_ADV0, ST_ADV1, ST_ADV_RD, ST_ADV_CHK, ST_ADV_CLR, ST_ADV_LV,
        ST_MIN_RD, ST_MIN_CMP,
        ST_RW_ROW0, ST_RW_ROW1, ST_RW_ROW2, ST_RW_NZ, ST_RW_CI, ST_RW_LJ, ST_RW_DIV,
        ST_RDW, ST_DONE
    } state_t;

    state_t state_reg;

    logic [VALUE_W-1:0] rs_mem [0:RS_DEPTH-1];
    logic [ROW_AW-1:0] ci_mem [0:MAX_NONZEROS-1];
    logic [PART_W-1:0] pt_mem [0:MAX_ROWS-1];
    logic              dn_mem [0:MAX_NONZEROS-1];
    logic [LEVEL_W-1:0] lv_mem [0:MAX_ROWS-1];
    logic [WEIGHT_W-1:0] wt_mem [0:MAX_NONZEROS-1];

    logic [VALUE_W-1:0]  rs_rd_reg;
    logic [ROW_AW-1:0]   ci_rd_reg;
    logic [PART_W-1:0]   pt_rd_reg;
    logic                dn_rd_reg;
    logic [LEVEL_W-1:0]  lv_rd_reg;
    logic [WEIGHT_W-1:0] wt_rd_reg;

    srlt_item_t          item_reg;
    logic [NZ_AW-1:0]    clr_reg;
    logic [ROW_AW-1:0]   i_reg;
    logic [PTR_W-1:0]    t_reg;
    logic [PTR_W-1:0]    s_reg;
    logic [PTR_W-1:0]    e_reg;
    logic [LEVEL_W-1:0]  m_reg;
    logic [LEVEL_W-1:0]  li_reg;
    logic                dn_keep_reg;
    logic [PART_W-1:0]   pa_reg;
    logic                full_reg;
    srlt_result_t        res_reg;

    logic [RS_AW-1:0]  rs_ra;
    logic [NZ_AW-1:0]  ci_ra;
    logic [ROW_AW-1:0] pt_ra;
    logic [NZ_AW-1:0]  dn_ra;
    logic [ROW_AW-1:0] lv_ra;
    logic [NZ_AW-1:0]  wt_ra;

    logic               rs_we, ci_we, pt_we, dn_we, lv_we, wt_we;
    logic [NZ_AW-1:0]   dn_wa;
    logic               dn_wd;
    logic [ROW_AW-1:0]  lv_wa;
    logic [LEVEL_W-1:0] lv_wd;
    logic [NZ_AW-1:0]   wt_wa;
    logic [WEIGHT_W-1:0] wt_wd;

    logic [PTR_W-1:0]   rs_clamped;
    logic [RS_AW-1:0]   row_next;
    logic [RS_AW-1:0]   i_next;
    logic               i_more;
    logic [LEVEL_W:0]   lsum;
    logic [LEVEL_W:0]   ltwice;
    logic [DIV_W-1:0]   divisor;
    logic               div_start, div_busy, div_done;
    logic [WEIGHT_W-1:0] div_q;

    assign rs_clamped = (rs_rd_reg > VALUE_W'(MAX_NONZEROS)) ? PTR_W'(MAX_NONZEROS)
                                                             : PTR_W'(rs_rd_reg);
    assign row_next = RS_AW'(item_reg.row) + 1'b1;
    assign i_next   = {1'b0, i_reg} + 1'b1;
    assign i_more   = COUNT_W'(i_next) < rows_used;
    assign lsum     = {1'b0, li_reg} + {1'b0, lv_rd_reg};
    assign ltwice   = {m_reg, 1'b0};
    assign divisor  = (lsum < ltwice) ? DIV_W'(1) : DIV_W'(lsum - ltwice) + 1'b1;
    assign div_start = (state_reg == ST_RW_LJ);

    srlt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        rs_ra = item_reg.row;
        ci_ra = item_reg.entry;
        pt_ra = item_reg.row[ROW_AW-1:0];
        dn_ra = item_reg.entry;
        lv_ra = i_reg;
        wt_ra = item_reg.entry;
        case (state_reg)
            ST_CA1:     begin pt_ra = ci_rd_reg; lv_ra = ci_rd_reg; end
            ST_ADV0:    rs_ra = row_next;
            ST_ADV_RD:  dn_ra = t_reg[NZ_AW-1:0];
            ST_ADV_CHK: lv_ra = item_reg.row[ROW_AW-1:0];
            ST_ADV_CLR: lv_ra = item_reg.row[ROW_AW-1:0];
            ST_RW_ROW0: rs_ra = RS_AW'(i_reg);
            ST_RW_ROW1: rs_ra = i_next;
            ST_RW_NZ:   ci_ra = t_reg[NZ_AW-1:0];
            ST_RW_CI:   lv_ra = ci_rd_reg;
            default:    ;
        endcase
    end

    always_comb begin
        rs_we = (state_reg == ST_EXEC) && (item_reg.action == ACT_LOAD_START)
                && (item_reg.row <= ROWF_W'(MAX_ROWS));
        ci_we = (state_reg == ST_EXEC) && (item_reg.action == ACT_LOAD_COL)
                && (item_reg.value < VALUE_W'(MAX_ROWS));
        pt_we = (state_reg == ST_EXEC) && (item_reg.action == ACT_LOAD_PART)
                && (item_reg.row < ROWF_W'(MAX_ROWS));
        dn_we = 1'b0;
        dn_wa = item_reg.entry;
        dn_wd = 1'b1;
        lv_we = 1'b0;
        lv_wa = item_reg.row[ROW_AW-1:0];
        lv_wd = lv_rd_reg + 1'b1;
        wt_we = 1'b0;
        wt_wa = t_reg[NZ_AW-1:0];
        wt_wd = (div_q == '0) ? WEIGHT_W'(1) : div_q;
        case (state_reg)
            ST_CLEAR: begin
                dn_we = 1'b1;
                dn_wa = clr_reg;
                dn_wd = 1'b0;
                lv_we = (clr_reg < NZ_AW'(MAX_ROWS));
                lv_wa = clr_reg[ROW_AW-1:0];
                lv_wd = '0;
                wt_we = 1'b1;
                wt_wa = clr_reg;
                wt_wd = '0;
            end
            ST_EXEC:    dn_we = (item_reg.action == ACT_MARK);
            ST_ADV_CLR: begin
                dn_we = (t_reg < e_reg);
                dn_wa = t_reg[NZ_AW-1:0];
                dn_wd = 1'b0;
            end
            ST_ADV_LV:  lv_we = full_reg && (lv_rd_reg != LEVEL_MAX);
            ST_RW_DIV:  wt_we = div_done;
            default:    ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rs_we) rs_mem[item_reg.row] <= item_reg.value;
        rs_rd_reg <= rs_mem[rs_ra];
    end

    always_ff @(posedge aclk) begin
        if (ci_we) ci_mem[item_reg.entry] <= item_reg.value[ROW_AW-1:0];
        ci_rd_reg <= ci_mem[ci_ra];
    end

    always_ff @(posedge aclk) begin
        if (pt_we) pt_mem[item_reg.row[ROW_AW-1:0]] <= item_reg.value[PART_W-1:0];
        pt_rd_reg <= pt_mem[pt_ra];
    end

    always_ff @(posedge aclk) begin
        if (dn_we) dn_mem[dn_wa] <= dn_wd;
        dn_rd_reg <= dn_mem[dn_ra];
    end

    always_ff @(posedge aclk) begin
        if (lv_we) lv_mem[lv_wa] <= lv_wd;
        lv_rd_reg <= lv_mem[lv_ra];
    end

    always_ff @(posedge aclk) begin
        if (wt_we) wt_mem[wt_wa] <= wt_wd;
        wt_rd_reg <= wt_mem[wt_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == NZ_AW'(MAX_NONZEROS - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (in_valid) begin
                        item_reg  <= in_item;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    res_reg   <= '0;
                    i_reg     <= '0;
                    state_reg <= ST_DONE;
                    case (item_reg.action)
                        ACT_CAN_ADD: begin
                            if (item_reg.row < ROWF_W'(MAX_ROWS)) state_reg <= ST_CA1;
                        end
                        ACT_ADVANCE: begin
                            if (item_reg.row < rows_used) state_reg <= ST_ADV0;
                        end
                        ACT_REWEIGH, ACT_MIN_LEVEL: state_reg <= ST_MIN_RD;
                        ACT_READ_WT: state_reg <= ST_RDW;
                        default:     ;
                    endcase
                end
                ST_CA1: begin
                    dn_keep_reg <= dn_rd_reg;
                    pa_reg      <= pt_rd_reg;
                    state_reg   <= ST_CA2;
                end
                ST_CA2: begin
                    res_reg.flag <= !dn_keep_reg && (pa_reg == pt_rd_reg)
                                    && (lv_rd_reg >= item_reg.level_below);
                    state_reg    <= ST_DONE;
                end
                ST_ADV0: begin
                    s_reg     <= rs_clamped;
                    t_reg     <= rs_clamped;
                    state_reg <= ST_ADV1;
                end
                ST_ADV1: begin
                    e_reg     <= rs_clamped;
                    state_reg <= ST_ADV_RD;
                end
                ST_ADV_RD: begin
                    if (t_reg < e_reg) begin
                        state_reg <= ST_ADV_CHK;
                    end else begin
                        t_reg     <= s_reg;
                        state_reg <= ST_ADV_CLR;
                    end
                end
                ST_ADV_CHK: begin
                    if (!dn_rd_reg) begin
                        full_reg  <= 1'b0;
                        state_reg <= ST_ADV_LV;
                    end else begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_ADV_RD;
                    end
                end
                ST_ADV_CLR: begin
                    if (t_reg < e_reg) begin
                        t_reg <= t_reg + 1'b1;
                    end else begin
                        full_reg  <= 1'b1;
                        state_reg <= ST_ADV_LV;
                    end
                end
                ST_ADV_LV: begin
                    if (full_reg && (lv_rd_reg != LEVEL_MAX)) begin
                        res_reg.flag      <= 1'b1;
                        res_reg.level_out <= lv_rd_reg + 1'b1;
                    end else begin
                        res_reg.level_out <= lv_rd_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_MIN_RD: state_reg <= ST_MIN_CMP;
                ST_MIN_CMP: begin
                    if ((i_reg == '0) || (lv_rd_reg < m_reg)) m_reg <= lv_rd_reg;
                    if (i_more) begin
                        i_reg     <= i_next[ROW_AW-1:0];
                        state_reg <= ST_MIN_RD;
                    end else if (item_reg.action == ACT_MIN_LEVEL) begin
                        res_reg.level_out <= ((i_reg == '0) || (lv_rd_reg < m_reg))
                                             ? lv_rd_reg : m_reg;
                        state_reg <= ST_DONE;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= ST_RW_ROW0;
                    end
                end
                ST_RW_ROW0: state_reg <= ST_RW_ROW1;
                ST_RW_ROW1: begin
                    t_reg     <= rs_clamped;
                    li_reg    <= lv_rd_reg;
                    state_reg <= ST_RW_ROW2;
                end
                ST_RW_ROW2: begin
                    e_reg     <= rs_clamped;
                    state_reg <= ST_RW_NZ;
                end
                ST_RW_NZ: begin
                    if (t_reg < e_reg) begin
                        state_reg <= ST_RW_CI;
                    end else if (i_more) begin
                        i_reg     <= i_next[ROW_AW-1:0];
                        state_reg <= ST_RW_ROW0;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_RW_CI: state_reg <= ST_RW_LJ;
                ST_RW_LJ: state_reg <= ST_RW_DIV;
                ST_RW_DIV: begin
                    if (div_done) begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_RW_NZ;
                    end
                end
                ST_RDW: begin
                    res_reg.weight_out <= wt_rd_reg;
                    state_reg          <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("Divider started while busy.");

    a_weight_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RW_DIV && div_done) |-> (div_q != '0))
        else $error("Computed weight is zero.");

    a_check_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADV_CHK) |-> (t_reg < e_reg))
        else $error("Done bit checked outside the row range.");

    a_can_add_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CA2) |-> ($past(state_reg) == ST_CA1))
        else $error("Can-add second read without first read.");

endmodule

// ===== design/sparse_row_level_tracker.sv =====
// ----------------------------------------------------------------------------
// sparse_row_level_tracker
// Row structure, done bits, levels and weights for a matrix-powers schedule.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Every memory has one read port with a
// registered output. An advance reads the row bounds, checks the done bits of
// the row and, if all are set, clears them and raises the row level unless it
// is at its maximum. A minimum-level query reads the level of every row in use.
// A reweigh finds the minimum first, then computes the weight of each nonzero
// of each row in the one-bit-per-cycle divider. After reset a clearing pass over
// the done, level and weight memories runs before the first transaction is accepted.
module sparse_row_level_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row, entry, level_below, value
    input  logic [47:0] s_tdata,
    // action
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // flag, level_out, weight_out
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srlt_pkg::*;

    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] rows_used;
    logic               m_valid_reg;
    srlt_result_t       m_data_reg;
    srlt_item_t         item;
    srlt_result_t       res;
    logic               res_valid;
    logic               res_ready;

    assign pready = 1'b1;
    assign prdata = {{(32 - COUNT_W){1'b0}}, row_count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_ROW_COUNT)) begin
            row_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign rows_used = (row_count_reg == '0) ? COUNT_W'(1)
                     : (row_count_reg > COUNT_W'(MAX_ROWS)) ? COUNT_W'(MAX_ROWS)
                     : row_count_reg;

    assign item.action      = s_tuser;
    assign item.row         = s_tdata[8:0];
    assign item.entry       = s_tdata[18:9];
    assign item.level_below = s_tdata[34:19];
    assign item.value       = s_tdata[45:35];

    srlt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .rows_used (rows_used),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
            if (res_valid) m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, m_data_reg};

endmodule

// ===== sim/sparse_row_level_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_level_tracker_tb
// Self-checking testbench for the sparse row level tracker.
// ----------------------------------------------------------------------------
// The full row structure, the columns of the nonzeros in use and every
// partition are loaded first. A short directed part covers the corner cases.
// Random phases then follow, each under its own row count. The largest
// share of random traffic marks a row's nonzeros and advances the row, so
// levels rise and the queries and weights change. A local model predicts
// every result, and the monitor checks each one in order.
// ----------------------------------------------------------------------------
module sparse_row_level_tracker_tb;
    import srlt_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE   = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 4'd15;
    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int NZ_USED = 256;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sparse_row_level_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Model state of the block.
    logic [COUNT_W-1:0]  rows_cfg = ROW_COUNT_RESET;
    logic [VALUE_W-1:0]  start_mem [0:MAX_ROWS];
    logic [PART_W-1:0]   col_mem [0:MAX_NONZEROS-1];
    logic [PART_W-1:0]   part_mem [0:MAX_ROWS-1];
    logic                done_mem [0:MAX_NONZEROS-1];
    logic [LEVEL_W-1:0]  level_mem [0:MAX_ROWS-1];
    logic [WEIGHT_W-1:0] weight_mem [0:MAX_NONZEROS-1];

    // Row starts as the stimulus has issued them.
    int plan_start [0:MAX_ROWS];

    srlt_item_t   pending_q [$];
    srlt_result_t awaited_q [$];
    srlt_item_t   cur_item;
    int  send_gap = 0;
    int  ready_gap = 0;
    int  hold_left = 0;
    int  hold_asks = 0;
    int  hold_seen = 0;
    bit  calm = 1'b0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    function automatic int rows_in_use();
        if (rows_cfg == 0) return 1;
        if (rows_cfg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_cfg);
    endfunction

    function automatic int clamp_nz(int v);
        return (v > MAX_NONZEROS) ? MAX_NONZEROS : v;
    endfunction

    function automatic logic [LEVEL_W-1:0] lowest_level();
        logic [LEVEL_W-1:0] m;
        m = level_mem[0];
        for (int i = 1; i < rows_in_use(); i++)
            if (level_mem[i] < m) m = level_mem[i];
        return m;
    endfunction

    function automatic srlt_result_t track_step(srlt_item_t it);
        srlt_result_t res;
        int s, e, j, d, m;
        bit full;
        res = '0;
        case (it.action)
            ACT_LOAD_START: if (it.row <= MAX_ROWS) start_mem[it.row] = it.value;
            ACT_LOAD_COL: if (it.value < MAX_ROWS) col_mem[it.entry] = it.value[PART_W-1:0];
            ACT_LOAD_PART: if (it.row < MAX_ROWS) part_mem[it.row] = it.value[PART_W-1:0];
            ACT_MARK: done_mem[it.entry] = 1'b1;
            ACT_CAN_ADD: begin
                if (it.row < MAX_ROWS) begin
                    j = col_mem[it.entry];
                    res.flag = !done_mem[it.entry] && part_mem[it.row] == part_mem[j]
                               && level_mem[j] >= it.level_below;
                end
            end
            ACT_ADVANCE: begin
                if (it.row < rows_in_use()) begin
                    s = clamp_nz(start_mem[it.row]);
                    e = clamp_nz(start_mem[it.row + 1]);
                    full = 1'b1;
                    for (int t = s; t < e; t++)
                        if (!done_mem[t]) full = 1'b0;
                    if (full) begin
                        for (int t = s; t < e; t++) done_mem[t] = 1'b0;
                        if (level_mem[it.row] != LEVEL_MAX) begin
                            level_mem[it.row]++;
                            res.flag = 1'b1;
                        end
                    end
                    res.level_out = level_mem[it.row];
                end
            end
            ACT_REWEIGH: begin
                m = lowest_level();
                for (int i = 0; i < rows_in_use(); i++) begin
                    s = clamp_nz(start_mem[i]);
                    e = clamp_nz(start_mem[i + 1]);
                    for (int t = s; t < e; t++) begin
                        j = col_mem[t];
                        d = int'(level_mem[i]) + int'(level_mem[j]) - 2 * m;
                        if (d < 0) d = 0;
                        weight_mem[t] = WEIGHT_TOP / (d + 1);
                        if (weight_mem[t] == 0) weight_mem[t] = 1;
                    end
                end
            end
            ACT_READ_WT: res.weight_out = weight_mem[it.entry];
            ACT_MIN_LEVEL: res.level_out = lowest_level();
            default: ;
        endcase
        return res;
    endfunction

    function automatic srlt_item_t make_item(logic [ACTION_W-1:0] act, int r, int e, int lb,
                                             int v);
        srlt_item_t it;
        it.action = act;
        it.row = r[ROWF_W-1:0];
        it.entry = e[ENTRY_W-1:0];
        it.level_below = lb[LEVEL_W-1:0];
        it.value = v[VALUE_W-1:0];
        return it;
    endfunction

    task automatic send(logic [ACTION_W-1:0] act, int r, int e, int lb, int v);
        if (act == ACT_LOAD_START && r <= MAX_ROWS) plan_start[r] = v;
        pending_q.push_back(make_item(act, r, e, lb, v));
    endtask

    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_q.size() != 0 || s_tvalid || awaited_q.size() != 0);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_row_count(int v);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_ROW_COUNT;
        pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rows_cfg = v[COUNT_W-1:0];
    endtask

    task automatic random_traffic(int n);
        int done_cnt, k, r, s, e, skip;
        done_cnt = 0;
        while (done_cnt < n) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                r = $urandom_range(0, rows_in_use() - 1);
                s = plan_start[r];
                e = plan_start[r + 1];
                skip = ($urandom_range(0, 5) == 0) ? $urandom_range(s, e) : -1;
                if (e - s <= 8) begin
                    for (int t = s; t < e; t++) begin
                        if (t != skip) begin
                            send(ACT_MARK, $urandom_range(0, 511), t, $urandom, 0);
                            done_cnt++;
                        end
                    end
                end
                send(ACT_ADVANCE, r, $urandom_range(0, 1023), $urandom, 0);
                done_cnt++;
            end else begin
                if (k < 55)
                    send(ACT_CAN_ADD, $urandom_range(0, 255), $urandom_range(0, NZ_USED - 1),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 3), 0);
                else if (k < 63) send(ACT_MARK, 0, $urandom_range(0, 1023), 0, 0);
                else if (k < 70) send(ACT_READ_WT, 0, $urandom_range(0, 1023), 0, 0);
                else if (k < 76) send(ACT_MIN_LEVEL, $urandom_range(0, 511), 0, 0, 0);
                else if (k < 78) send(ACT_REWEIGH, 0, 0, 0, 0);
                else if (k < 83)
                    send(ACT_LOAD_COL, 0, $urandom_range(0, 1023), 0, $urandom_range(0, 300));
                else if (k < 87)
                    send(ACT_LOAD_PART, $urandom_range(0, 300), 0, 0, $urandom_range(0, 1024));
                else if (k < 90) send(ACT_ADVANCE, $urandom_range(0, 511), 0, 0, 0);
                else if (k < 95) begin
                    r = $urandom_range(1, MAX_ROWS - 1);
                    send(ACT_LOAD_START, r, 0, 0,
                         $urandom_range(plan_start[r - 1], plan_start[r + 1]));
                end else if (k < 97)
                    send(ACT_LOAD_START, $urandom_range(MAX_ROWS + 1, 511), 0, 0,
                         $urandom_range(0, 1024));
                else
                    send(($urandom_range(0, 1) != 0) ? ACT_UNKNOWN : ACT_SPARE,
                         $urandom_range(0, 511), $urandom_range(0, 1023),
                         $urandom_range(0, 65535), $urandom_range(0, 1024));
                done_cnt++;
            end
        end
    endtask

    // Sender.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) awaited_q.push_back(track_step(cur_item));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    cur_item = pending_q.pop_front();
                    s_tdata <= {2'b00, cur_item.value, cur_item.level_below,
                                cur_item.entry, cur_item.row};
                    s_tuser <= cur_item.action;
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) ready_gap <= $urandom_range(1, 17);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        srlt_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.flag = m_tdata[0];
            got.level_out = m_tdata[16:1];
            got.weight_out = m_tdata[36:17];
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
            end else begin
                want = awaited_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected flag=%0d level=%0d weight=%0d, got flag=%0d level=%0d weight=%0d",
                                 want.flag, want.level_out, want.weight_out,
                                 got.flag, got.level_out, got.weight_out);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int counts [5];
        for (int i = 0; i < MAX_NONZEROS; i++) begin
            done_mem[i] = 1'b0;
            weight_mem[i] = '0;
            col_mem[i] = '0;
        end
        for (int i = 0; i < MAX_ROWS; i++) begin
            level_mem[i] = '0;
            part_mem[i] = '0;
        end
        for (int i = 0; i <= MAX_ROWS; i++) start_mem[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        write_row_count(256);

        // Full structure: row starts, the columns in use, every partition.
        plan_start[0] = 0;
        send(ACT_LOAD_START, 0, 0, 0, 0);
        for (int i = 1; i <= MAX_ROWS; i++)
            send(ACT_LOAD_START, i, 0, 0, plan_start[i - 1] + $urandom_range(0, 1));
        for (int t = 0; t < NZ_USED; t++)
            send(ACT_LOAD_COL, 0, t, 0, $urandom_range(0, 255));
        for (int i = 0; i < MAX_ROWS; i++)
            send(ACT_LOAD_PART, i, 0, 0, $urandom_range(0, 3) + 256 * $urandom_range(0, 3));

        // Directed corner cases.
        send(ACT_LOAD_COL, 0, 1023, 0, 256);
        send(ACT_LOAD_COL, 0, 1022, 0, 1024);
        send(ACT_LOAD_START, 300, 0, 0, 7);
        send(ACT_LOAD_START, 511, 0, 0, 1024);
        send(ACT_LOAD_PART, 256, 0, 0, 5);
        send(ACT_LOAD_PART, 511, 0, 0, 5);
        send(ACT_LOAD_PART, 3, 0, 0, 1024);
        send(ACT_MARK, 0, NZ_USED - 1, 0, 0);
        send(ACT_CAN_ADD, 256, 5, 0, 0);
        send(ACT_CAN_ADD, 511, 1023, 65535, 0);
        send(ACT_CAN_ADD, 3, NZ_USED - 1, 0, 0);
        send(ACT_CAN_ADD, 3, NZ_USED - 3, 65535, 0);
        send(ACT_ADVANCE, 511, 0, 0, 0);
        send(ACT_ADVANCE, 256, 0, 0, 0);
        send(ACT_READ_WT, 0, 1023, 0, 0);
        send(ACT_MIN_LEVEL, 0, 0, 0, 0);
        send(ACT_UNKNOWN, 511, 1023, 65535, 1024);
        send(ACT_SPARE, 0, 0, 0, 0);
        send(ACT_LOAD_START, 9, 0, 0, plan_start[10] + 2);
        send(ACT_ADVANCE, 9, 0, 0, 0);
        send(ACT_LOAD_START, 9, 0, 0, plan_start[8]);
        send(ACT_LOAD_START, 256, 0, 0, NZ_USED);
        send(ACT_ADVANCE, 255, 0, 0, 0);
        send(ACT_REWEIGH, 0, 0, 0, 0);
        send(ACT_READ_WT, 0, 0, 0, 0);
        wait_idle();

        counts = '{20, 12, 12, 20, 30};
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_row_count(17);
                1: write_row_count(1);
                2: write_row_count(0);
                3: write_row_count(511);
                default: write_row_count(256);
            endcase
            if (ph == 4) calm = 1'b1;
            if (ph == 0) begin
                hold_asks++;
                random_traffic(10);
                wait_idle();
                random_traffic(counts[ph] - 10);
            end else begin
                random_traffic(counts[ph]);
            end
            wait_idle();
        end

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && awaited_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
